// ----- design/dte_pkg.sv -----
// Shared constants and the CORDIC arctangent table for direction_to_euler_angles.
package dte_pkg;

    // Angle constants
    localparam logic [30:0] ANG_90_Q24  = 31'd1509949440;
    localparam logic [24:0] ANG_180_Q16 = 25'd11796480;

    // Sequencer state codes
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_SQA  = 4'd2;
    localparam logic [3:0] ST_SQI  = 4'd3;
    localparam logic [3:0] ST_ATN  = 4'd4;
    localparam logic [3:0] ST_ATI  = 4'd5;
    localparam logic [3:0] ST_ATD  = 4'd6;
    localparam logic [3:0] ST_LRED = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // Which angle the arctangent unit is working on
    localparam logic [1:0] ANG_PITCH = 2'd0;
    localparam logic [1:0] ANG_YAW   = 2'd1;
    localparam logic [1:0] ANG_ROLL  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ROLL_EN = 2'd0;
    localparam logic [1:0] REG_UP_X    = 2'd1;
    localparam logic [1:0] REG_UP_Y    = 2'd2;
    localparam logic [1:0] REG_UP_Z    = 2'd3;

    // Multiplier operand selection codes
    localparam logic [3:0] MUL_XX   = 4'd0;
    localparam logic [3:0] MUL_YY   = 4'd1;
    localparam logic [3:0] MUL_UYZ  = 4'd2;
    localparam logic [3:0] MUL_UZY  = 4'd3;
    localparam logic [3:0] MUL_UZX  = 4'd4;
    localparam logic [3:0] MUL_UXZ  = 4'd5;
    localparam logic [3:0] MUL_UXY  = 4'd6;
    localparam logic [3:0] MUL_UYX  = 4'd7;
    localparam logic [3:0] MUL_LYX  = 4'd8;
    localparam logic [3:0] MUL_LXY  = 4'd9;
    localparam logic [3:0] MUL_SQ_END    = 4'd2;
    localparam logic [3:0] MUL_CROSS_END = 4'd8;
    localparam logic [3:0] MUL_DEN_END   = 4'd10;

    // atan(2^-i) in degrees, Q6.24
    function automatic logic [29:0] atan_tab(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            5'd24: v = 30'd57;
            5'd25: v = 30'd29;
            5'd26: v = 30'd14;
            5'd27: v = 30'd7;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/direction_to_euler_angles.sv -----
// Direction vector to pitch, yaw and roll angles on one shared multiplier and CORDIC unit.
// Time to a result depends on the normalizing shifts, the square root, the CORDIC passes and roll.
// Throughput: one request at a time; in_stall is high from acceptance until the result
// is loaded into the output register. A vertical direction goes straight to the output.
// Reset: sequencer idle, output empty, roll off, up vector (0, 0, 1.0).
module direction_to_euler_angles #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] pitch_deg,
    output logic signed [24:0] yaw_deg,
    output logic signed [24:0] roll_deg,
    output logic               vertical,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    // Configuration registers
    logic               roll_en_reg;
    logic signed [31:0] up_x_reg, up_y_reg, up_z_reg;

    // Sequencer and working registers
    logic [3:0]         state_reg, state_next;
    logic signed [31:0] dx_reg, dy_reg, dz_reg;
    logic [3:0]         midx_reg, mend_reg, pidx_reg;
    logic               pvld_reg;
    logic signed [63:0] prod_reg, tmp_reg;
    logic signed [63:0] lx_reg, ly_reg, lz_reg, den_reg;
    logic [63:0]        sq_v_reg, sq_res_reg, sq_one_reg;
    logic [63:0]        mx_reg, my_reg;
    logic               xneg_reg, yneg_reg, azero_reg;
    logic [1:0]         which_reg;
    logic signed [33:0] cx_reg, cy_reg, acc_reg;
    logic [4:0]         step_reg;
    logic signed [24:0] res_pitch_reg, res_yaw_reg, res_roll_reg;
    logic               res_vert_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [23:0] pitch_reg;
    logic signed [24:0] yaw_reg, roll_reg;
    logic               vert_reg;

    logic in_acc, out_free;
    assign in_stall  = (state_reg != dte_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign pitch_deg = pitch_reg;
    assign yaw_deg   = yaw_reg;
    assign roll_deg  = roll_reg;
    assign vertical  = vert_reg;

    // Shared multiplier operand selection
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    always_comb
    begin
        case (midx_reg)
            dte_pkg::MUL_XX:  begin mul_a = dx_reg;   mul_b = dx_reg; end
            dte_pkg::MUL_YY:  begin mul_a = dy_reg;   mul_b = dy_reg; end
            dte_pkg::MUL_UYZ: begin mul_a = up_y_reg; mul_b = dz_reg; end
            dte_pkg::MUL_UZY: begin mul_a = up_z_reg; mul_b = dy_reg; end
            dte_pkg::MUL_UZX: begin mul_a = up_z_reg; mul_b = dx_reg; end
            dte_pkg::MUL_UXZ: begin mul_a = up_x_reg; mul_b = dz_reg; end
            dte_pkg::MUL_UXY: begin mul_a = up_x_reg; mul_b = dy_reg; end
            dte_pkg::MUL_UYX: begin mul_a = up_y_reg; mul_b = dx_reg; end
            dte_pkg::MUL_LYX: begin mul_a = ly_reg[31:0]; mul_b = dx_reg; end
            dte_pkg::MUL_LXY: begin mul_a = lx_reg[31:0]; mul_b = dy_reg; end
            default:          begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Cross-product half terms
    logic signed [63:0] prod_half, cross_diff;
    assign prod_half  = prod_reg >>> 1;
    assign cross_diff = tmp_reg - prod_half;

    // Square root step
    logic [63:0] sq_trial;
    assign sq_trial = sq_res_reg + sq_one_reg;

    // CORDIC step
    logic signed [33:0] cx_sh, cy_sh;
    assign cx_sh = cx_reg >>> step_reg;
    assign cy_sh = cy_reg >>> step_reg;

    // Final angle: clamp, round, apply quadrant
    logic [30:0]        acc_c;
    logic [31:0]        acc_rnd;
    logic signed [25:0] ang_q, ang_x, ang_f;
    always_comb
    begin
        if (acc_reg < 0)
            acc_c = '0;
        else if (acc_reg > 34'(dte_pkg::ANG_90_Q24))
            acc_c = dte_pkg::ANG_90_Q24;
        else
            acc_c = acc_reg[30:0];
        acc_rnd = {1'b0, acc_c} + 32'd128;
        ang_q   = 26'(acc_rnd[31:8]);
        ang_x   = xneg_reg ? 26'(dte_pkg::ANG_180_Q16) - ang_q : ang_q;
        ang_f   = azero_reg ? 26'sd0 : (yneg_reg ? -ang_x : ang_x);
    end

    // Magnitudes for the roll arctangent and the reduction test
    logic [63:0] den_mag, lz_mag;
    logic        l_big;
    assign den_mag = den_reg[63] ? 64'd0 - den_reg : den_reg;
    assign lz_mag  = lz_reg[63] ? 64'd0 - lz_reg : lz_reg;
    always_comb
    begin
        logic [63:0] ax, ay;
        ax    = lx_reg[63] ? 64'd0 - lx_reg : lx_reg;
        ay    = ly_reg[63] ? 64'd0 - ly_reg : ly_reg;
        l_big = (|ax[63:30]) || (|ay[63:30]) || (|lz_mag[63:30]);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dte_pkg::ST_IDLE:
                if (in_acc)
                    state_next = (dir_x == 0 && dir_y == 0) ? dte_pkg::ST_OUT : dte_pkg::ST_MUL;
            dte_pkg::ST_MUL:
                if (midx_reg == mend_reg && !pvld_reg)
                begin
                    if (mend_reg == dte_pkg::MUL_SQ_END)
                        state_next = dte_pkg::ST_SQA;
                    else if (mend_reg == dte_pkg::MUL_CROSS_END)
                        state_next = dte_pkg::ST_LRED;
                    else
                        state_next = dte_pkg::ST_ATN;
                end
            dte_pkg::ST_SQA:
                if (sq_one_reg <= sq_v_reg)
                    state_next = dte_pkg::ST_SQI;
            dte_pkg::ST_SQI:
                if (sq_one_reg == 0)
                    state_next = dte_pkg::ST_ATN;
            dte_pkg::ST_ATN:
                if (mx_reg == 0 && my_reg == 0)
                    state_next = dte_pkg::ST_ATD;
                else if (!(|mx_reg[63:30]) && !(|my_reg[63:30]))
                    state_next = dte_pkg::ST_ATI;
            dte_pkg::ST_ATI:
                if (step_reg == LAST_STEP)
                    state_next = dte_pkg::ST_ATD;
            dte_pkg::ST_ATD:
                if (which_reg == dte_pkg::ANG_PITCH)
                    state_next = dte_pkg::ST_ATN;
                else if (which_reg == dte_pkg::ANG_YAW && roll_en_reg)
                    state_next = dte_pkg::ST_MUL;
                else
                    state_next = dte_pkg::ST_OUT;
            dte_pkg::ST_LRED:
                if (!l_big)
                    state_next = dte_pkg::ST_MUL;
            dte_pkg::ST_OUT:
                if (out_free)
                    state_next = dte_pkg::ST_IDLE;
            default:
                state_next = dte_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dte_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            roll_en_reg   <= 1'b0;
            up_x_reg      <= '0;
            up_y_reg      <= '0;
            up_z_reg      <= 32'sd65536;
            pvld_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    dte_pkg::REG_ROLL_EN: roll_en_reg <= cfg_data[0];
                    dte_pkg::REG_UP_X:    up_x_reg    <= cfg_data;
                    dte_pkg::REG_UP_Y:    up_y_reg    <= cfg_data;
                    dte_pkg::REG_UP_Z:    up_z_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == dte_pkg::ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == dte_pkg::ST_MUL)
                pvld_reg <= (midx_reg != mend_reg);
            else
                pvld_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dte_pkg::ST_IDLE:
            begin
                dx_reg        <= dir_x;
                dy_reg        <= dir_y;
                dz_reg        <= dir_z;
                midx_reg      <= dte_pkg::MUL_XX;
                mend_reg      <= dte_pkg::MUL_SQ_END;
                res_pitch_reg <= '0;
                res_yaw_reg   <= '0;
                res_roll_reg  <= '0;
                res_vert_reg  <= (dir_x == 0 && dir_y == 0);
            end
            dte_pkg::ST_MUL:
            begin
                // issue next product
                if (midx_reg != mend_reg)
                begin
                    prod_reg <= mul_p;
                    pidx_reg <= midx_reg;
                    midx_reg <= midx_reg + 4'd1;
                end
                // consume previous product
                if (pvld_reg)
                begin
                    case (pidx_reg)
                        dte_pkg::MUL_XX:  sq_v_reg <= prod_reg;
                        dte_pkg::MUL_YY:  sq_v_reg <= sq_v_reg + prod_reg;
                        dte_pkg::MUL_UZY: lx_reg <= cross_diff;
                        dte_pkg::MUL_UXZ: ly_reg <= cross_diff;
                        dte_pkg::MUL_UYX: lz_reg <= cross_diff;
                        dte_pkg::MUL_LYX: tmp_reg <= prod_reg;
                        dte_pkg::MUL_LXY: den_reg <= tmp_reg - prod_reg;
                        default:          tmp_reg <= prod_half;
                    endcase
                end
                sq_one_reg <= 64'd1 << 62;
                sq_res_reg <= '0;
                // roll operands follow the denominator
                mx_reg    <= den_mag;
                my_reg    <= lz_mag;
                xneg_reg  <= den_reg[63];
                yneg_reg  <= lz_reg[63];
                which_reg <= dte_pkg::ANG_ROLL;
            end
            dte_pkg::ST_SQA:
            begin
                if (sq_one_reg > sq_v_reg)
                    sq_one_reg <= sq_one_reg >> 2;
            end
            dte_pkg::ST_SQI:
            begin
                if (sq_one_reg != 0)
                begin
                    if (sq_v_reg >= sq_trial)
                    begin
                        sq_v_reg   <= sq_v_reg - sq_trial;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_one_reg;
                    end
                    else
                        sq_res_reg <= sq_res_reg >> 1;
                    sq_one_reg <= sq_one_reg >> 2;
                end
                // pitch operands: atan2(-z, horizontal length)
                mx_reg    <= sq_res_reg;
                my_reg    <= 64'(dz_reg[31] ? -33'(dz_reg) : 33'(dz_reg));
                xneg_reg  <= 1'b0;
                yneg_reg  <= (dz_reg > 0);
                which_reg <= dte_pkg::ANG_PITCH;
            end
            dte_pkg::ST_ATN:
            begin
                azero_reg <= (mx_reg == 0 && my_reg == 0);
                acc_reg   <= '0;
                step_reg  <= '0;
                if ((|mx_reg[63:30]) || (|my_reg[63:30]))
                begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                end
                cx_reg <= 34'(mx_reg[29:0]);
                cy_reg <= 34'(my_reg[29:0]);
            end
            dte_pkg::ST_ATI:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg  <= cx_reg + cy_sh;
                    cy_reg  <= cy_reg - cx_sh;
                    acc_reg <= acc_reg + 34'(dte_pkg::atan_tab(step_reg));
                end
                else if (cy_reg < 0)
                begin
                    cx_reg  <= cx_reg - cy_sh;
                    cy_reg  <= cy_reg + cx_sh;
                    acc_reg <= acc_reg - 34'(dte_pkg::atan_tab(step_reg));
                end
                step_reg <= step_reg + 5'd1;
            end
            dte_pkg::ST_ATD:
            begin
                case (which_reg)
                    dte_pkg::ANG_PITCH: res_pitch_reg <= ang_f[24:0];
                    dte_pkg::ANG_YAW:   res_yaw_reg   <= ang_f[24:0];
                    default:            res_roll_reg  <= ang_f[24:0];
                endcase
                // yaw operands: atan2(y, x)
                mx_reg    <= 64'(dx_reg[31] ? -33'(dx_reg) : 33'(dx_reg));
                my_reg    <= 64'(dy_reg[31] ? -33'(dy_reg) : 33'(dy_reg));
                xneg_reg  <= dx_reg[31];
                yneg_reg  <= dy_reg[31];
                which_reg <= dte_pkg::ANG_YAW;
                midx_reg  <= dte_pkg::MUL_UYZ;
                mend_reg  <= dte_pkg::MUL_CROSS_END;
            end
            dte_pkg::ST_LRED:
            begin
                if (l_big)
                begin
                    lx_reg <= lx_reg >>> 1;
                    ly_reg <= ly_reg >>> 1;
                    lz_reg <= lz_reg >>> 1;
                end
                midx_reg <= dte_pkg::MUL_LYX;
                mend_reg <= dte_pkg::MUL_DEN_END;
            end
            dte_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    pitch_reg <= res_pitch_reg[23:0];
                    yaw_reg   <= res_yaw_reg;
                    roll_reg  <= res_roll_reg;
                    vert_reg  <= res_vert_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
